// ----- src/acm_pkg.sv -----
// acm_pkg: shared types and constants for the packed two-word move block.
// Holds the letter codes, move numbers, item and plan structs and the engine states.
// No dependencies.
`timescale 1ns / 1ps

package acm_pkg;

	// field widths fixed by the packed state layout
	localparam int NUM_LETTERS = 31;
	localparam int LETTERS_W   = 2 * NUM_LETTERS;
	localparam int LEN_W       = 5;
	localparam int OUT_LEN_W   = 6;
	localparam int CMD_W       = 4;
	localparam int CAP_W       = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd29;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [1:0] letter_t;

	localparam letter_t LETTER_X     = 2'd0;
	localparam letter_t LETTER_X_INV = 2'd1;
	localparam letter_t LETTER_Y     = 2'd2;
	localparam letter_t LETTER_Y_INV = 2'd3;
	localparam letter_t LETTER_FLIP  = 2'd1;

	// move numbers
	localparam logic [CMD_W-1:0] MOVE_INV_FIRST       = 4'd0;
	localparam logic [CMD_W-1:0] MOVE_INV_SECOND      = 4'd1;
	localparam logic [CMD_W-1:0] MOVE_FIRST_MUL       = 4'd2;
	localparam logic [CMD_W-1:0] MOVE_FIRST_MUL_INV   = 4'd3;
	localparam logic [CMD_W-1:0] MOVE_SECOND_MUL      = 4'd4;
	localparam logic [CMD_W-1:0] MOVE_SECOND_MUL_INV  = 4'd5;
	localparam logic [CMD_W-1:0] MOVE_CONJ_FIRST_X    = 4'd6;
	localparam logic [CMD_W-1:0] MOVE_CONJ_FIRST_XI   = 4'd7;
	localparam logic [CMD_W-1:0] MOVE_CONJ_FIRST_Y    = 4'd8;
	localparam logic [CMD_W-1:0] MOVE_CONJ_FIRST_YI   = 4'd9;
	localparam logic [CMD_W-1:0] MOVE_CONJ_SECOND_X   = 4'd10;
	localparam logic [CMD_W-1:0] MOVE_CONJ_SECOND_XI  = 4'd11;
	localparam logic [CMD_W-1:0] MOVE_CONJ_SECOND_Y   = 4'd12;
	localparam logic [CMD_W-1:0] MOVE_CONJ_SECOND_YI  = 4'd13;

	// how the engine builds the new target word
	typedef struct packed {
		logic    err;        // bad move or input too long
		logic    tgt_second; // the second word is rewritten
		logic    conj;       // wrap with gen and its inverse, cancelling
		letter_t gen;
		logic    inv_main;   // target word read reversed and inverted
		logic    tail_en;    // other word appended with cancellation
		logic    tail_inv;   // other word read reversed and inverted
	} plan_t;

	typedef struct packed {
		logic [LETTERS_W-1:0] letters;
		logic [LEN_W-1:0]     first_len;
		logic [LEN_W-1:0]     second_len;
		plan_t                plan;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GEN_PRE,
		S_MAIN,
		S_TAIL,
		S_GEN_POST,
		S_CHECK,
		S_PACK1,
		S_PACK2,
		S_DONE
	} acm_state_t;

endpackage

// ----- src/acm_front.sv -----
// acm_front: accepts input transfers, checks them and decodes the move into a plan.
// Depends on acm_pkg; feeds acm_queue.
`timescale 1ns / 1ps

module acm_front #(
	parameter int MAX_LETTERS = 31
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [acm_pkg::LETTERS_W-1:0]  packed_letters,
	input  logic [acm_pkg::LEN_W-1:0]      first_length,
	input  logic [acm_pkg::LEN_W-1:0]      second_length,
	input  logic [acm_pkg::CMD_W-1:0]      command,
	output logic                           push_valid,
	input  logic                           push_ready,
	output acm_pkg::item_t                 push_item
);
	import acm_pkg::*;

	logic                 valid_s1;
	item_t                item_s1;
	plan_t                plan;
	logic [LEN_W:0]       in_total;

	// decode the move
	always_comb begin
		plan = '0;
		unique case (command)
			MOVE_INV_FIRST: begin
				plan.inv_main = 1'b1;
			end
			MOVE_INV_SECOND: begin
				plan.tgt_second = 1'b1;
				plan.inv_main   = 1'b1;
			end
			MOVE_FIRST_MUL: begin
				plan.tail_en = 1'b1;
			end
			MOVE_FIRST_MUL_INV: begin
				plan.tail_en  = 1'b1;
				plan.tail_inv = 1'b1;
			end
			MOVE_SECOND_MUL: begin
				plan.tgt_second = 1'b1;
				plan.tail_en    = 1'b1;
			end
			MOVE_SECOND_MUL_INV: begin
				plan.tgt_second = 1'b1;
				plan.tail_en    = 1'b1;
				plan.tail_inv   = 1'b1;
			end
			MOVE_CONJ_FIRST_X: begin
				plan.conj = 1'b1;
				plan.gen  = LETTER_X;
			end
			MOVE_CONJ_FIRST_XI: begin
				plan.conj = 1'b1;
				plan.gen  = LETTER_X_INV;
			end
			MOVE_CONJ_FIRST_Y: begin
				plan.conj = 1'b1;
				plan.gen  = LETTER_Y;
			end
			MOVE_CONJ_FIRST_YI: begin
				plan.conj = 1'b1;
				plan.gen  = LETTER_Y_INV;
			end
			MOVE_CONJ_SECOND_X: begin
				plan.tgt_second = 1'b1;
				plan.conj       = 1'b1;
				plan.gen        = LETTER_X;
			end
			MOVE_CONJ_SECOND_XI: begin
				plan.tgt_second = 1'b1;
				plan.conj       = 1'b1;
				plan.gen        = LETTER_X_INV;
			end
			MOVE_CONJ_SECOND_Y: begin
				plan.tgt_second = 1'b1;
				plan.conj       = 1'b1;
				plan.gen        = LETTER_Y;
			end
			MOVE_CONJ_SECOND_YI: begin
				plan.tgt_second = 1'b1;
				plan.conj       = 1'b1;
				plan.gen        = LETTER_Y_INV;
			end
			default: begin
				plan.err = 1'b1;
			end
		endcase
		// flag an input state that is too long
		in_total = {1'b0, first_length} + {1'b0, second_length};
		if (in_total > (LEN_W+1)'(MAX_LETTERS)) begin
			plan.err = 1'b1;
		end
	end

	assign in_ready = !valid_s1 || push_ready;

	// hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.letters    <= packed_letters;
			item_s1.first_len  <= first_length;
			item_s1.second_len <= second_length;
			item_s1.plan       <= plan;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// ----- src/acm_queue.sv -----
// acm_queue: two-entry queue of classified items between front and engine.
// Depends on acm_pkg.
`timescale 1ns / 1ps

module acm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  acm_pkg::item_t  push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output acm_pkg::item_t  pop_item
);
	import acm_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- src/acm_back.sv -----
// acm_back: letter-serial engine that rebuilds the target word on a cancelling stack,
// checks the length cap and repacks the state. Holds the length_cap register.
// Depends on acm_pkg; fed by acm_queue.
`timescale 1ns / 1ps

module acm_back #(
	parameter int MAX_LETTERS = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_enable,
	input  logic [acm_pkg::CAP_W-1:0]       cfg_write_data,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  acm_pkg::item_t                  pop_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [acm_pkg::LETTERS_W-1:0]   result_letters,
	output logic [acm_pkg::OUT_LEN_W-1:0]   result_first_length,
	output logic [acm_pkg::OUT_LEN_W-1:0]   result_second_length,
	output logic [acm_pkg::OUT_LEN_W-1:0]   result_total,
	output logic                            over_cap,
	output logic                            request_error
);
	import acm_pkg::*;

	// a conjugated word may grow by two letters
	localparam int DEPTH = MAX_LETTERS + 2;
	localparam int CNT_W = $clog2(DEPTH + 1);

	acm_state_t              state_q, state_d;
	item_t                   item_q;
	logic [CAP_W-1:0]        length_cap_q;
	logic [LEN_W-1:0]        k_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [2*DEPTH-1:0]      stack_q;
	logic [LETTERS_W-1:0]    res_letters_q;
	logic [OUT_LEN_W-1:0]    res_first_q;
	logic [OUT_LEN_W-1:0]    res_second_q;
	logic [OUT_LEN_W-1:0]    res_total_q;
	logic                    over_q;
	logic                    err_q;

	letter_t                 letter_arr [NUM_LETTERS];
	logic [LEN_W-1:0]        tgt_len;
	logic [LEN_W-1:0]        oth_len;
	logic                    f_second;
	logic [LEN_W-1:0]        f_len;
	logic                    f_rev;
	logic                    f_inv;
	logic [LEN_W-1:0]        f_idx;
	logic [LEN_W-1:0]        f_pos;
	letter_t                 f_letter;
	logic                    seg_done;
	letter_t                 cur_letter;
	logic                    cancel_en;
	logic                    do_pop;
	logic                    emit_stack;
	logic                    pack_done;
	logic [OUT_LEN_W-1:0]    new_total;
	logic [OUT_LEN_W-1:0]    cap_eff;
	logic                    over_d;

	// view the packed letters as an array
	always_comb begin
		for (int i = 0; i < NUM_LETTERS; i++) begin
			letter_arr[i] = item_q.letters[2*i +: 2];
		end
	end

	assign tgt_len = item_q.plan.tgt_second ? item_q.second_len : item_q.first_len;
	assign oth_len = item_q.plan.tgt_second ? item_q.first_len : item_q.second_len;

	// pick the word and direction read in this state
	always_comb begin
		f_second = 1'b0;
		f_len    = '0;
		f_rev    = 1'b0;
		f_inv    = 1'b0;
		unique case (state_q)
			S_MAIN: begin
				f_second = item_q.plan.tgt_second;
				f_len    = tgt_len;
				f_rev    = item_q.plan.inv_main;
				f_inv    = item_q.plan.inv_main;
			end
			S_TAIL: begin
				f_second = !item_q.plan.tgt_second;
				f_len    = oth_len;
				f_rev    = item_q.plan.tail_inv;
				f_inv    = item_q.plan.tail_inv;
			end
			S_PACK1, S_PACK2: begin
				f_second = !item_q.plan.tgt_second;
				f_len    = oth_len;
				f_rev    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// fetch one letter of the chosen word
	assign f_idx    = f_rev ? (f_len - LEN_W'(1) - k_q) : k_q;
	assign f_pos    = (f_second ? item_q.first_len : '0) + f_idx;
	assign f_letter = letter_arr[f_pos] ^ (f_inv ? LETTER_FLIP : '0);
	assign seg_done = (k_q == f_len);

	// letter fed to the stack and whether it may cancel
	always_comb begin
		cur_letter = f_letter;
		cancel_en  = 1'b1;
		unique case (state_q)
			S_GEN_PRE:  cur_letter = item_q.plan.gen;
			S_GEN_POST: cur_letter = item_q.plan.gen ^ LETTER_FLIP;
			S_MAIN:     cancel_en  = item_q.plan.conj;
			default: begin
			end
		endcase
	end

	assign do_pop = cancel_en && (cnt_q != '0) && (stack_q[1:0] == (cur_letter ^ LETTER_FLIP));

	// length check against the clamped cap
	assign new_total = OUT_LEN_W'(cnt_q) + OUT_LEN_W'(oth_len);
	assign cap_eff   = ({1'b0, length_cap_q} > OUT_LEN_W'(MAX_LETTERS)) ?
		OUT_LEN_W'(MAX_LETTERS) : {1'b0, length_cap_q};
	assign over_d    = (new_total > cap_eff);

	// packing runs last letter first: second word reversed, then first word reversed
	assign emit_stack = (state_q == S_PACK1) ? item_q.plan.tgt_second : !item_q.plan.tgt_second;
	assign pack_done  = emit_stack ? (cnt_q == '0) : seg_done;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (pop_valid) begin
					if (pop_item.plan.err) begin
						state_d = S_DONE;
					end else if (pop_item.plan.conj) begin
						state_d = S_GEN_PRE;
					end else begin
						state_d = S_MAIN;
					end
				end
			end
			S_GEN_PRE:  state_d = S_MAIN;
			S_MAIN: begin
				if (seg_done) begin
					if (item_q.plan.tail_en) begin
						state_d = S_TAIL;
					end else if (item_q.plan.conj) begin
						state_d = S_GEN_POST;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_TAIL: begin
				if (seg_done) begin
					state_d = S_CHECK;
				end
			end
			S_GEN_POST: state_d = S_CHECK;
			S_CHECK:    state_d = over_d ? S_DONE : S_PACK1;
			S_PACK1: begin
				if (pack_done) begin
					state_d = S_PACK2;
				end
			end
			S_PACK2: begin
				if (pack_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign pop_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// length cap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_cap_q <= CAP_RESET;
		end else if (cfg_write_enable) begin
			length_cap_q <= cfg_write_data;
		end
	end

	// datapath: load, stack steps, check and repack
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop_valid) begin
					item_q        <= pop_item;
					k_q           <= '0;
					cnt_q         <= '0;
					res_letters_q <= '0;
					res_first_q   <= '0;
					res_second_q  <= '0;
					res_total_q   <= '0;
					over_q        <= 1'b0;
					err_q         <= pop_item.plan.err;
				end
			end
			S_GEN_PRE, S_GEN_POST, S_MAIN, S_TAIL: begin
				if ((state_q == S_MAIN || state_q == S_TAIL) && seg_done) begin
					k_q <= '0;
				end else begin
					if (state_q == S_MAIN || state_q == S_TAIL) begin
						k_q <= k_q + LEN_W'(1);
					end
					if (do_pop) begin
						stack_q <= stack_q >> 2;
						cnt_q   <= cnt_q - CNT_W'(1);
					end else begin
						stack_q <= {stack_q[2*DEPTH-3:0], cur_letter};
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
			end
			S_CHECK: begin
				res_total_q  <= new_total;
				over_q       <= over_d;
				res_first_q  <= item_q.plan.tgt_second ?
					OUT_LEN_W'(item_q.first_len) : OUT_LEN_W'(cnt_q);
				res_second_q <= item_q.plan.tgt_second ?
					OUT_LEN_W'(cnt_q) : OUT_LEN_W'(item_q.second_len);
			end
			S_PACK1, S_PACK2: begin
				if (pack_done) begin
					k_q <= '0;
				end else if (emit_stack) begin
					res_letters_q <= {res_letters_q[LETTERS_W-3:0], stack_q[1:0]};
					stack_q       <= stack_q >> 2;
					cnt_q         <= cnt_q - CNT_W'(1);
				end else begin
					res_letters_q <= {res_letters_q[LETTERS_W-3:0], f_letter};
					k_q           <= k_q + LEN_W'(1);
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign result_letters       = res_letters_q;
	assign result_first_length  = res_first_q;
	assign result_second_length = res_second_q;
	assign result_total         = res_total_q;
	assign over_cap             = over_q;
	assign request_error        = err_q;

	// result consistency
	a_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && over_cap |-> result_letters == '0)
		else $error("over-cap result carries letters");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_error |-> !over_cap && result_total == '0 && result_letters == '0)
		else $error("error result not cleared");

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_total == result_first_length + result_second_length)
		else $error("total does not match word lengths");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> cnt_q <= CNT_W'(DEPTH))
		else $error("stack count beyond depth");

endmodule

// ----- src/ac_move_packed_state_top.sv -----
// ac_move_packed_state_top: one move on a rank-two presentation held as packed words.
// Depends on acm_pkg, acm_front, acm_queue and acm_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries packed_letters, first_length,
//   second_length and command; output channel (out_valid/out_ready) carries
//   the repacked state, the new lengths and total, over_cap and request_error.
//   cfg_write_enable/cfg_write_data write length_cap (reset 29).
//   The front registers and classifies each transfer and hands it to a
//   two-entry queue, so up to three items wait while the engine works.
//   The engine handles one item at a time, one letter per cycle on its
//   cancelling stack; a flagged request skips the letter loop and goes
//   straight to the result.
//   Sustained rate is set by the engine's letter loop, one item per
//   engine pass plus the output transfer.
//   Reset empties front, queue and engine and restores length_cap.
//   When the receiver stalls the result holds and the engine waits; the
//   front keeps taking transfers until the queue and its own register fill.
`timescale 1ns / 1ps

module ac_move_packed_state_top #(
	parameter int MAX_LETTERS = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_enable,
	input  logic [acm_pkg::CAP_W-1:0]       cfg_write_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [acm_pkg::LETTERS_W-1:0]   packed_letters,
	input  logic [acm_pkg::LEN_W-1:0]       first_length,
	input  logic [acm_pkg::LEN_W-1:0]       second_length,
	input  logic [acm_pkg::CMD_W-1:0]       command,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [acm_pkg::LETTERS_W-1:0]   result_letters,
	output logic [acm_pkg::OUT_LEN_W-1:0]   result_first_length,
	output logic [acm_pkg::OUT_LEN_W-1:0]   result_second_length,
	output logic [acm_pkg::OUT_LEN_W-1:0]   result_total,
	output logic                            over_cap,
	output logic                            request_error
);
	import acm_pkg::*;

	logic   push_valid;
	logic   push_ready;
	item_t  push_item;
	logic   pop_valid;
	logic   pop_ready;
	item_t  pop_item;

	// accept and classify
	acm_front #(
		.MAX_LETTERS (MAX_LETTERS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.packed_letters (packed_letters),
		.first_length   (first_length),
		.second_length  (second_length),
		.command        (command),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	// decouple front and engine
	acm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// carry out the move
	acm_back #(
		.MAX_LETTERS (MAX_LETTERS)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_write_enable     (cfg_write_enable),
		.cfg_write_data       (cfg_write_data),
		.pop_valid            (pop_valid),
		.pop_ready            (pop_ready),
		.pop_item             (pop_item),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.result_letters       (result_letters),
		.result_first_length  (result_first_length),
		.result_second_length (result_second_length),
		.result_total         (result_total),
		.over_cap             (over_cap),
		.request_error        (request_error)
	);

endmodule
